// ===== rtl/core/lrukv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
// Used by lrukv_age_bank and lru_key_value_cache_unit; no dependencies.
package lrukv_pkg;

  localparam int unsigned CapW   = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Register index taken from paddr[2]
  localparam logic RegCapacity = 1'b0;

  // Operation codes carried in tuser
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  // Recency update request to the age bank
  typedef struct packed {
    logic touch;      // make the selected slot most recent
    logic fill;       // slot is newly filled: age every other valid slot
    logic set_valid;  // mark the selected slot valid
  } lrukv_touch_t;

endpackage

// ===== rtl/core/lrukv_age_bank.sv =====
// Per-slot valid bits and LRU ages of the cache, with a probe read port.
// Depends on lrukv_pkg for the touch request struct.
module lrukv_age_bank #(
  parameter  int unsigned ENTRIES = 16,
  localparam int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned AgeW    = IdxW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lrukv_pkg::lrukv_touch_t    touch_i,
  input  logic [IdxW-1:0]            slot_i,
  input  logic [IdxW-1:0]            probe_idx_i,
  output logic                       probe_valid_o,
  output logic [AgeW-1:0]            probe_age_o
);

  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [AgeW-1:0]     age_q [ENTRIES];
  logic [AgeW-1:0]     age_d [ENTRIES];
  logic [AgeW-1:0]     limit;

  assign limit         = age_q[slot_i];
  assign probe_valid_o = valid_q[probe_idx_i];
  assign probe_age_o   = age_q[probe_idx_i];

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < ENTRIES; i++) begin
      age_d[i] = age_q[i];
      if (touch_i.touch) begin
        if (IdxW'(i) == slot_i) begin
          age_d[i] = '0;
        end else if (valid_q[i] && (touch_i.fill || (age_q[i] < limit))) begin
          age_d[i] = age_q[i] + AgeW'(1);
        end
      end
    end
    if (touch_i.set_valid) begin
      valid_d[slot_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

endmodule

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// Top level of the fully associative LRU key/value cache.
// Depends on lrukv_pkg and lrukv_age_bank.
//
// Usage:
//   s_axis: one item per request. tuser = operation (0 get, 1 put),
//   tdata = lookup_key, store_value. m_axis: one result item per request
//   with hit, read_value, evicted and evicted_key packed in tdata.
//   APB: register 0 (byte address 0) holds capacity, clamped to 1..ENTRIES
//   when used. Write it only while the block is idle.
// Timing:
//   The keys sit in a memory that is scanned one slot per
//   cycle; a single comparator checks each slot against the key and tracks
//   the first match, the lowest free slot and the oldest valid slot.
//   After acceptance the scan state reads every slot in turn, then the
//   update state does the write-back and age update and the finish state
//   loads the output register; a new item is taken only once the result
//   has been loaded into the output register.
//   s_axis_tready is high only while idle.
// Reset: all slots invalid, no entries in use, capacity 16.
// Stall: a result waits in the output register until taken; the next item
//   may be accepted meanwhile but its result is held back until then.
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [63:0]                       s_axis_tdata,  // lookup_key, store_value
  input  logic                              s_axis_tuser,  // operation
  // stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [71:0]                       m_axis_tdata,  // hit, read_value, evicted,
                                                           // evicted_key, zero fill
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lrukv_pkg::PAddrW-1:0]      paddr,
  input  logic [lrukv_pkg::PDataW-1:0]      pwdata,
  output logic [lrukv_pkg::PDataW-1:0]      prdata,
  output logic                              pready
);

  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned ScanW = $clog2(ENTRIES + 1);
  localparam int unsigned CapW  = lrukv_pkg::CapW;
  localparam int unsigned EW    = (CntW > CapW) ? CntW : CapW;
  localparam int unsigned DW    = lrukv_pkg::DataW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  state_e            state_q;

  // configuration
  logic [CapW-1:0]   cap_q;
  logic              cfg_we;
  logic [EW-1:0]     cap_ext, eff_cap;

  // request
  logic              op_q;
  logic [DW-1:0]     key_q, val_q;

  // scan bookkeeping
  logic [ScanW-1:0]  scan_q;
  logic              first_q;
  logic [IdxW-1:0]   eval_q;
  logic              found_q, free_q, old_q;
  logic [IdxW-1:0]   found_idx_q, free_idx_q, old_idx_q;
  logic [IdxW-1:0]   old_age_q;
  logic [DW-1:0]     old_key_q;
  logic [CntW-1:0]   used_q;

  // memories
  logic [DW-1:0]     key_mem [ENTRIES];
  logic [DW-1:0]     val_mem [ENTRIES];
  logic [DW-1:0]     key_rd_q, val_rd_q;
  logic [IdxW-1:0]   rd_addr;

  // age bank
  lrukv_pkg::lrukv_touch_t touch;
  logic [IdxW-1:0]   target;
  logic              probe_valid;
  logic [IdxW-1:0]   probe_age;

  // update decisions
  logic              do_fill, do_evict, mem_we, key_we;

  // result
  logic              res_hit_q, res_get_q, res_ev_q;
  logic [DW-1:0]     res_evk_q;
  logic              out_hit_q, out_ev_q;
  logic [DW-1:0]     out_rd_q, out_evk_q;
  logic              out_valid_q;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == lrukv_pkg::RegCapacity);
  assign prdata = (paddr[2] == lrukv_pkg::RegCapacity) ?
                  lrukv_pkg::PDataW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lrukv_pkg::CapReset;
    end else if (cfg_we) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  assign cap_ext = EW'(cap_q);
  assign eff_cap = (cap_q == '0) ? EW'(1) :
                   (cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext;

  // ---------------- update decisions ----------------
  always_comb begin
    do_fill  = 1'b0;
    do_evict = 1'b0;
    target   = found_idx_q;
    if (!found_q && (op_q == lrukv_pkg::OpPut)) begin
      if ((EW'(used_q) < eff_cap) && free_q) begin
        do_fill = 1'b1;
        target  = free_idx_q;
      end else if (old_q) begin
        do_evict = 1'b1;
        target   = old_idx_q;
      end
    end
  end

  assign key_we = (state_q == ST_UPDATE) && (do_fill || do_evict);
  assign mem_we = key_we ||
                  ((state_q == ST_UPDATE) && found_q && (op_q == lrukv_pkg::OpPut));

  always_comb begin
    touch.touch     = (state_q == ST_UPDATE) && (found_q || do_fill || do_evict);
    touch.fill      = do_fill;
    touch.set_valid = (state_q == ST_UPDATE) && do_fill;
  end

  // ---------------- key and value memories ----------------
  assign rd_addr = scan_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[target] <= key_q;
    end
    key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      val_mem[target] <= val_q;
    end
    val_rd_q <= val_mem[found_idx_q];
  end

  lrukv_age_bank #(
    .ENTRIES(ENTRIES)
  ) u_age_bank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .touch_i       (touch),
    .slot_i        (target),
    .probe_idx_i   (eval_q),
    .probe_valid_o (probe_valid),
    .probe_age_o   (probe_age)
  );

  // ---------------- sequencer ----------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_evk_q, out_ev_q, out_rd_q, out_hit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= lrukv_pkg::OpGet;
      key_q       <= '0;
      val_q       <= '0;
      scan_q      <= '0;
      first_q     <= 1'b1;
      eval_q      <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      old_q       <= 1'b0;
      found_idx_q <= '0;
      free_idx_q  <= '0;
      old_idx_q   <= '0;
      old_age_q   <= '0;
      old_key_q   <= '0;
      used_q      <= '0;
      res_hit_q   <= 1'b0;
      res_get_q   <= 1'b0;
      res_ev_q    <= 1'b0;
      res_evk_q   <= '0;
      out_hit_q   <= 1'b0;
      out_ev_q    <= 1'b0;
      out_rd_q    <= '0;
      out_evk_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the finish state reloads or holds the output register itself
      if (out_valid_q && m_axis_tready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tuser;
            key_q   <= s_axis_tdata[31:0];
            val_q   <= s_axis_tdata[63:32];
            scan_q  <= '0;
            first_q <= 1'b1;
            found_q <= 1'b0;
            free_q  <= 1'b0;
            old_q   <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // slot read last cycle is checked now, next slot is read
          eval_q  <= rd_addr;
          first_q <= 1'b0;
          scan_q  <= scan_q + ScanW'(1);
          if (!first_q) begin
            if (probe_valid) begin
              if (!found_q && (key_rd_q == key_q)) begin
                found_q     <= 1'b1;
                found_idx_q <= eval_q;
              end
              if (!old_q || (probe_age > old_age_q)) begin
                old_q     <= 1'b1;
                old_idx_q <= eval_q;
                old_age_q <= probe_age;
                old_key_q <= key_rd_q;
              end
            end else if (!free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= eval_q;
            end
          end
          if (scan_q == ScanW'(ENTRIES)) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          res_hit_q <= found_q;
          res_get_q <= (op_q == lrukv_pkg::OpGet);
          res_ev_q  <= do_evict;
          res_evk_q <= do_evict ? old_key_q : '0;
          if (do_fill) begin
            used_q <= used_q + CntW'(1);
          end
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          // hold the result until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= res_hit_q;
            out_rd_q    <= (res_hit_q && res_get_q) ? val_rd_q : '1;
            out_ev_q    <= res_ev_q;
            out_evk_q   <= res_evk_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/tb_lru_key_value_cache_unit.sv =====
// Testbench for lru_key_value_cache_unit: streams get/put requests, predicts each result
// from a shadow copy of the slots and their recency order, and compares every result item.
// Depends on lrukv_pkg and the RTL of the cache unit only.
`timescale 1ns / 1ps

module tb_lru_key_value_cache_unit;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned CYCLE_CAP = 400000;
  localparam int unsigned POOL_SIZE = 20;
  localparam logic [lrukv_pkg::PAddrW-1:0] AddrCapacity = {lrukv_pkg::RegCapacity, 2'b00};
  localparam logic [lrukv_pkg::PAddrW-1:0] AddrSpare    = {~lrukv_pkg::RegCapacity, 2'b00};

  typedef struct packed {
    logic                        op;
    logic [lrukv_pkg::DataW-1:0] key;
    logic [lrukv_pkg::DataW-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic                        hit;
    logic [lrukv_pkg::DataW-1:0] read_value;
    logic                        evicted;
    logic [lrukv_pkg::DataW-1:0] evicted_key;
  } cache_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [63:0]                  s_axis_tdata = '0;  // lookup_key, store_value
  logic                         s_axis_tuser = 1'b0;  // operation
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [71:0]                  m_axis_tdata;  // hit, read_value, evicted, evicted_key, zero fill
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [lrukv_pkg::PAddrW-1:0] paddr = '0;
  logic [lrukv_pkg::PDataW-1:0] pwdata = '0;
  logic [lrukv_pkg::PDataW-1:0] prdata;
  logic                         pready;

  lru_key_value_cache_unit #(.ENTRIES(ENTRIES)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  cache_req_t  pending_reqs[$];
  cache_rsp_t  expected_rsps[$];
  logic [lrukv_pkg::DataW-1:0] key_pool[POOL_SIZE];

  // Shadow of the cache contents
  logic [lrukv_pkg::DataW-1:0] shadow_key[ENTRIES];
  logic [lrukv_pkg::DataW-1:0] shadow_val[ENTRIES];
  bit                          shadow_valid[ENTRIES];
  int unsigned                 shadow_age[ENTRIES];
  int unsigned                 shadow_used = 0;
  logic [lrukv_pkg::CapW-1:0]  shadow_cap = lrukv_pkg::CapReset;

  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned evictions_seen = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_age[i] = 0;
    end
  end

  // Make slot s most recent; valid slots younger than limit grow one older.
  function automatic void promote_slot(int s, int unsigned limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && i != s && shadow_age[i] < limit) shadow_age[i]++;
    end
    shadow_age[s] = 0;
  endfunction

  function automatic cache_rsp_t lru_lookup(cache_req_t rq);
    cache_rsp_t  rsp;
    int          found;
    int          free_slot;
    int          oldest;
    int unsigned cap_eff;
    found = -1;
    free_slot = -1;
    oldest = -1;
    rsp = '{hit: 1'b0, read_value: '1, evicted: 1'b0, evicted_key: '0};
    cap_eff = (shadow_cap == 0) ? 1 : (shadow_cap > ENTRIES) ? ENTRIES : shadow_cap;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i]) begin
        if (found < 0 && shadow_key[i] == rq.key) found = i;
        if (oldest < 0 || shadow_age[i] > shadow_age[oldest]) oldest = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (found >= 0) begin
      rsp.hit = 1'b1;
      if (rq.op == lrukv_pkg::OpGet) rsp.read_value = shadow_val[found];
      else shadow_val[found] = rq.value;
      promote_slot(found, shadow_age[found]);
    end else if (rq.op == lrukv_pkg::OpPut) begin
      if (shadow_used < cap_eff && free_slot >= 0) begin
        shadow_valid[free_slot] = 1'b1;
        shadow_key[free_slot] = rq.key;
        shadow_val[free_slot] = rq.value;
        promote_slot(free_slot, ENTRIES + 1);
        shadow_used++;
      end else if (oldest >= 0) begin
        rsp.evicted = 1'b1;
        rsp.evicted_key = shadow_key[oldest];
        shadow_key[oldest] = rq.key;
        shadow_val[oldest] = rq.value;
        promote_slot(oldest, shadow_age[oldest]);
      end
    end
    return rsp;
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    cache_req_t rq;
    bit         idle;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rq = pending_reqs.pop_front();
        expected_rsps.push_back(lru_lookup(rq));
        items_sent++;
      end
      idle = (items_sent >= 700 && items_sent < 850) ? 1'b0 : ($urandom_range(0, 99) < 28);
      if (pending_reqs.size() > 0 && !idle) begin
        rq = pending_reqs[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rq.value, rq.key};
        s_axis_tuser <= rq.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_result(input logic [71:0] raw);
    cache_rsp_t got;
    cache_rsp_t want;
    got.hit = raw[0];
    got.read_value = raw[32:1];
    got.evicted = raw[33];
    got.evicted_key = raw[65:34];
    if (expected_rsps.size() == 0) begin
      errors++;
      $display("%0t: result with no request outstanding: got %h", $time, got);
      return;
    end
    want = expected_rsps.pop_front();
    results_checked++;
    if (got.hit) hits_seen++;
    if (got.evicted) evictions_seen++;
    if (got.hit !== want.hit || got.read_value !== want.read_value ||
        got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
      errors++;
      $display("%0t: result %0d mismatch: expected hit=%0b rd=%h ev=%0b evk=%h",
               $time, results_checked, want.hit, want.read_value, want.evicted,
               want.evicted_key);
      $display("%0t: result %0d mismatch:   actual hit=%0b rd=%h ev=%0b evk=%h",
               $time, results_checked, got.hit, got.read_value, got.evicted,
               got.evicted_key);
    end
  endtask

  // Result monitor with random back-pressure and one long hold-off
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    bit idle;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (results_checked == 400 && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        idle = (results_checked >= 700 && results_checked < 850) ? 1'b0 :
               ($urandom_range(0, 99) < 28);
        m_axis_tready <= !idle;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [lrukv_pkg::PAddrW-1:0] addr,
                           input logic [lrukv_pkg::PDataW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_cap = (addr == AddrCapacity) ? data[lrukv_pkg::CapW-1:0] : shadow_cap;
  endtask

  task automatic push_req(input logic op, input logic [lrukv_pkg::DataW-1:0] key,
                          input logic [lrukv_pkg::DataW-1:0] value);
    cache_req_t rq;
    rq.op = op;
    rq.key = key;
    rq.value = value;
    pending_reqs.push_back(rq);
  endtask

  // Hold the sender until every request has been answered
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(negedge clk_i);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i == 0 || $urandom_range(0, 2) == 0) key_pool[i] = $urandom();
    end
  endtask

  task automatic run_random(input int unsigned n);
    logic [lrukv_pkg::DataW-1:0] key;
    refresh_pool();
    @(negedge clk_i);
    for (int unsigned i = 0; i < n; i++) begin
      key = ($urandom_range(0, 3) == 0) ? $urandom() :
            key_pool[$urandom_range(0, POOL_SIZE - 1)];
      push_req(1'($urandom_range(0, 1)), key, $urandom());
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Capacity zero behaves as one slot
    write_reg(AddrCapacity, 32'd0);
    @(negedge clk_i);
    push_req(lrukv_pkg::OpGet, 32'h0000_0000, 32'h0000_0000);
    push_req(lrukv_pkg::OpPut, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(lrukv_pkg::OpPut, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(lrukv_pkg::OpGet, 32'h8000_0000, 32'h0000_0000);
    push_req(lrukv_pkg::OpGet, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_req(lrukv_pkg::OpPut, 32'h7FFF_FFFF, 32'h1234_5678);
    push_req(lrukv_pkg::OpGet, 32'h7FFF_FFFF, 32'h0000_0000);
    wait_drained();

    // Oversized capacity clamps to all slots; the spare address is ignored
    write_reg(AddrCapacity, 32'd31);
    write_reg(AddrSpare, 32'd1);
    @(negedge clk_i);
    push_req(lrukv_pkg::OpPut, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(lrukv_pkg::OpPut, 32'h0000_0000, 32'hFFFF_FFFF);
    push_req(lrukv_pkg::OpPut, 32'h7FFF_FFFE, 32'h0000_0001);
    push_req(lrukv_pkg::OpGet, 32'h7FFF_FFFE, 32'h5555_5555);
    push_req(lrukv_pkg::OpGet, 32'hFFFF_FFFE, 32'h0000_0000);
    push_req(lrukv_pkg::OpGet, 32'h0000_0000, 32'h0000_0000);
    push_req(lrukv_pkg::OpGet, 32'h7FFF_FFFF, 32'h0000_0000);
    wait_drained();

    // Capacity below the number of used slots: new keys evict, nothing is dropped
    write_reg(AddrCapacity, 32'd2);
    @(negedge clk_i);
    push_req(lrukv_pkg::OpPut, 32'h5555_5555, 32'hAAAA_AAAA);
    push_req(lrukv_pkg::OpPut, 32'hAAAA_AAAA, 32'h5555_5555);
    push_req(lrukv_pkg::OpGet, 32'h5555_5555, 32'h0000_0000);
    push_req(lrukv_pkg::OpGet, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(lrukv_pkg::OpGet, 32'h0000_0000, 32'h0000_0000);
    wait_drained();

    write_reg(AddrCapacity, 32'd31);
    run_random(350);
    write_reg(AddrCapacity, 32'd2);
    run_random(250);
    write_reg(AddrCapacity, 32'd16);
    run_random(250);
    write_reg(AddrCapacity, 32'd5);
    run_random(150);
    write_reg(AddrCapacity, 32'd1);
    run_random(150);

    repeat (ENTRIES + 8) @(posedge clk_i);
    $display("Covered %0d requests over capacities 0, 1, 2, 5, 16 and 31", items_sent);
    $display("Checked %0d results: %0d hits, %0d evictions", results_checked, hits_seen,
             evictions_seen);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
